/* design/mfcc_pkg.sv */
// ----------------------------------------------------------------------------
// mfcc_pkg
// Shared types, constants and the CRC-16/MODBUS byte update for the Modbus
// frame CRC checker.
// ----------------------------------------------------------------------------
package mfcc_pkg;

    localparam int TAIL_DEPTH_DEF  = 4;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CRC_METHOD   = 2'd0;
    localparam logic [1:0] CFG_START_OFFSET = 2'd1;
    localparam logic [1:0] CFG_CRC_BYTES    = 2'd2;

    localparam logic METHOD_MODBUS = 1'b1;

    typedef struct packed {
        logic       crc_method;
        logic [7:0] start_offset;
        logic [2:0] crc_bytes;
    } t_cfg;

    // One classified byte handed from the front part to the back part.
    typedef struct packed {
        logic       crc_en;     // crc_byte enters the CRC
        logic [7:0] crc_byte;
        logic       last;       // frame ends with this byte
        logic       too_short;
        logic       chk_crc;    // pass if the tail equals the final CRC
        logic       zero_ok;    // pass regardless of the CRC
        logic [7:0] exp_lo;     // tail byte expected to hold the CRC low byte
        logic [7:0] exp_hi;
    } t_job;

    // Reflected CRC-16 update over one byte, eight shift steps unrolled.
    function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                 input logic [7:0]  data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* design/mfcc_front.sv */
// ----------------------------------------------------------------------------
// mfcc_front
// Accepts frame bytes, keeps the tail delay line and byte count, and turns
// each byte into a job for the CRC back part.
// ----------------------------------------------------------------------------
module mfcc_front #(
    parameter int TAIL_DEPTH  = mfcc_pkg::TAIL_DEPTH_DEF,
    parameter int COUNT_WIDTH = mfcc_pkg::COUNT_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mfcc_pkg::t_cfg i_cfg,
    input  logic          i_accept,
    input  logic [7:0]    i_data_byte,
    input  logic          i_last_byte,
    output mfcc_pkg::t_job o_job
);
    import mfcc_pkg::*;

    localparam int DW  = $clog2(TAIL_DEPTH + 1);
    localparam int TIW = $clog2(TAIL_DEPTH);

    logic [7:0]             r_tail [TAIL_DEPTH];
    logic [7:0]             n_tail [TAIL_DEPTH];
    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] n_count;
    logic [DW-1:0]          delay;
    logic [TIW-1:0]         leave_idx;
    logic                   cb_fits;
    logic                   short_frame;
    logic                   all_zero;

    always_comb begin
        delay     = (int'(i_cfg.crc_bytes) > TAIL_DEPTH) ? DW'(TAIL_DEPTH)
                                                         : DW'(i_cfg.crc_bytes);
        leave_idx = TIW'(delay - DW'(1));
        cb_fits   = int'(i_cfg.crc_bytes) <= TAIL_DEPTH;

        n_tail[0] = i_data_byte;
        for (int k = 1; k < TAIL_DEPTH; k++) begin
            n_tail[k] = r_tail[k-1];
        end
        n_count = (&r_count) ? r_count : r_count + COUNT_WIDTH'(1);

        short_frame = n_count < (COUNT_WIDTH'(i_cfg.start_offset)
                                 + COUNT_WIDTH'(i_cfg.crc_bytes)
                                 + COUNT_WIDTH'(1));
        all_zero = 1'b1;
        for (int k = 0; k < TAIL_DEPTH; k++) begin
            if (k < int'(i_cfg.crc_bytes) && n_tail[k] != 8'h00) begin
                all_zero = 1'b0;
            end
        end

        o_job.crc_en    = r_count >= (COUNT_WIDTH'(i_cfg.start_offset)
                                      + COUNT_WIDTH'(delay));
        o_job.crc_byte  = (delay == '0) ? i_data_byte : r_tail[leave_idx];
        o_job.last      = i_last_byte;
        o_job.too_short = short_frame;
        o_job.chk_crc   = !short_frame && cb_fits
                          && (i_cfg.crc_method == METHOD_MODBUS)
                          && (i_cfg.crc_bytes == 3'd2);
        o_job.zero_ok   = !short_frame && cb_fits
                          && (i_cfg.crc_method != METHOD_MODBUS) && all_zero;
        o_job.exp_lo    = n_tail[1];
        o_job.exp_hi    = n_tail[0];
    end

    // The delay line and count restart after the last byte of each frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int k = 0; k < TAIL_DEPTH; k++) begin
                r_tail[k] <= 8'h00;
            end
        end else if (i_accept) begin
            if (i_last_byte) begin
                r_count <= '0;
                for (int k = 0; k < TAIL_DEPTH; k++) begin
                    r_tail[k] <= 8'h00;
                end
            end else begin
                r_count <= n_count;
                for (int k = 0; k < TAIL_DEPTH; k++) begin
                    r_tail[k] <= n_tail[k];
                end
            end
        end
    end

endmodule

/* design/mfcc_queue.sv */
// ----------------------------------------------------------------------------
// mfcc_queue
// Two-entry job queue between the front and back parts.
// ----------------------------------------------------------------------------
module mfcc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mfcc_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output mfcc_pkg::t_job o_job
);
    import mfcc_pkg::*;

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = r_count == 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* design/mfcc_back.sv */
// ----------------------------------------------------------------------------
// mfcc_back
// Runs the CRC accumulator over queued jobs and holds the frame result in an
// output register until it is taken.
// ----------------------------------------------------------------------------
module mfcc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    input  mfcc_pkg::t_job i_job,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic           o_frame_ok,
    output logic           o_too_short,
    output logic [15:0]    o_computed_crc
);
    import mfcc_pkg::*;

    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic        r_out_valid;
    logic        r_frame_ok;
    logic        r_too_short;
    logic [15:0] r_crc_out;
    logic        n_ok;

    assign o_pop = i_job_valid && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_crc = i_job.crc_en ? crc16_update(r_crc, i_job.crc_byte) : r_crc;
        n_ok  = i_job.zero_ok
                || (i_job.chk_crc && i_job.exp_lo == n_crc[7:0]
                    && i_job.exp_hi == n_crc[15:8]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= CRC_INIT;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_crc <= i_job.last ? CRC_INIT : n_crc;
            end
            if (o_pop && i_job.last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_job.last) begin
            r_frame_ok  <= n_ok;
            r_too_short <= i_job.too_short;
            r_crc_out   <= n_crc;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_frame_ok     = r_frame_ok;
    assign o_too_short    = r_too_short;
    assign o_computed_crc = r_crc_out;

endmodule

/* design/modbus_frame_crc_checker.sv */
// A frame result is registered in two steps: the last byte enters the job
// queue at its transfer edge, and the back part loads the output register
// when it pops that job.
// Throughput: one byte per cycle while the job queue is not full, set by the
// unrolled CRC update in the back part; a stalled output backs up through a two-entry job queue.
// Reset (synchronous, active low) loads the register defaults and clears the
// frame state at once; there is no clearing pass.
// ----------------------------------------------------------------------------
// modbus_frame_crc_checker
// Checks received frames byte by byte against a CRC-16/MODBUS trailer or a
// zero trailer, giving one result per frame.
// ----------------------------------------------------------------------------
module modbus_frame_crc_checker #(
    parameter int TAIL_DEPTH  = mfcc_pkg::TAIL_DEPTH_DEF,
    parameter int COUNT_WIDTH = mfcc_pkg::COUNT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // Byte input channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    // Result output channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_frame_ok,
    output logic        o_too_short,
    output logic [15:0] o_computed_crc
);
    import mfcc_pkg::*;

    // Configuration registers. Writes are to be made only while the block is idle;
    // the block does not enforce this. The front part reads them directly on every byte.
    t_cfg r_cfg;

    t_job front_job;
    t_job queue_job;
    logic queue_full;
    logic queue_valid;
    logic queue_pop;
    logic in_accept;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.crc_method   <= METHOD_MODBUS;
            r_cfg.start_offset <= 8'd0;
            r_cfg.crc_bytes    <= 3'd2;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_CRC_METHOD:   r_cfg.crc_method   <= i_cfg_data[0];
                CFG_START_OFFSET: r_cfg.start_offset <= i_cfg_data;
                CFG_CRC_BYTES:    r_cfg.crc_bytes    <= i_cfg_data[2:0];
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    // The input is held off only when the job queue is full, which depends
    // on registered state alone, so no combinational path runs from the
    // output stall to the input stall.
    assign o_in_stall = queue_full;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Front part: delay line, byte count and per-byte classification.
    mfcc_front #(
        .TAIL_DEPTH  (TAIL_DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_accept    (in_accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_job       (front_job)
    );

    // Short queue that lets the front and back parts stall independently.
    mfcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_job   (front_job),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_valid (queue_valid),
        .o_job   (queue_job)
    );

    // Back part: CRC accumulation, final compare and the output register.
    mfcc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (queue_valid),
        .i_job          (queue_job),
        .o_pop          (queue_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_frame_ok     (o_frame_ok),
        .o_too_short    (o_too_short),
        .o_computed_crc (o_computed_crc)
    );

endmodule
